>>> hw/rtl/skf_pkg.sv
package skf_pkg;

    // Fixed-point widths
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned GAIN_W  = 17;
    localparam int unsigned DENOM_W = 33;
    localparam int unsigned FRAC_W  = 16;

    // Gain of one in Q0.16, held in 17 bits
    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_PROCESS_NOISE = 1'b0;
    localparam logic REG_MEASURE_NOISE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DEN,
        S_DIV,
        S_MUL_X,
        S_MUL_P,
        S_COV,
        S_WB
    } t_state;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

>>> hw/rtl/skf_regs.sv
module skf_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_process_noise,
    output logic [31:0] o_measure_noise
);

    logic [31:0] r_process_noise;
    logic [31:0] r_measure_noise;
    logic        w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // Write the selected register at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise <= {15'd0, skf_pkg::ONE_Q16};
            r_measure_noise <= '0;
        end else if (w_wr) begin
            unique case (paddr[2])
                skf_pkg::REG_PROCESS_NOISE: r_process_noise <= pwdata;
                skf_pkg::REG_MEASURE_NOISE: r_measure_noise <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            skf_pkg::REG_PROCESS_NOISE: prdata = r_process_noise;
            skf_pkg::REG_MEASURE_NOISE: prdata = r_measure_noise;
            default:                    prdata = '0;
        endcase
    end

    assign o_process_noise = r_process_noise;
    assign o_measure_noise = r_measure_noise;

endmodule

>>> hw/rtl/skf_div.sv
module skf_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_dividend,
    input  logic [32:0]          i_divisor,
    output skf_pkg::t_div_status o_status,
    output logic [16:0]          o_quotient
);

    // Restoring divider for floor(dividend * 2^16 / divisor), dividend <= divisor,
    // one quotient bit per cycle, most significant first.
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [33:0] r_rem;
    logic [32:0] r_div;
    logic [15:0] r_q;
    logic [34:0] w_sub;
    logic        w_ge;
    logic [33:0] w_rem_next;
    logic        w_last;

    assign w_sub      = {1'b0, r_rem} - {2'b00, r_div};
    assign w_ge       = ~w_sub[34];
    assign w_rem_next = w_ge ? w_sub[33:0] : r_rem;
    assign w_last     = (r_cnt == 5'd0);

    // Control: start, count down, stop after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(skf_pkg::GAIN_W - 1);
        end else if (r_busy) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // Datapath: subtract, shift the remainder, shift in the quotient bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_dividend};
            r_div <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {w_rem_next[32:0], 1'b0};
            r_q   <= {r_q[14:0], w_ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_busy & w_last;
    assign o_quotient    = {r_q, w_ge};

endmodule

>>> hw/rtl/scalar_kalman_filter.sv
// One-dimensional Kalman filter (A = H = 1) on signed Q16.16 samples. Each sample
// transfer gives exactly one estimate transfer. Process noise Q sits at byte address
// 0 and measurement noise R at address 4 (unsigned Q16.16, reset 1.0 and 0); write
// them only while the filter is idle. A sample goes through the denominator step,
// the bit-per-cycle restoring divider that forms the gain, the two passes through
// the one shared 18x34 multiplier, the covariance update and the write-back. When
// the denominator is zero the divider is skipped. The input is not ready while a
// sample is in work, and is ready again in the cycle after the write-back, which
// waits while an earlier estimate has not been taken.
module scalar_kalman_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_estimate
);

    skf_pkg::t_state      r_state;
    skf_pkg::t_state      n_state;
    skf_pkg::t_div_status w_div_status;

    logic [31:0]        w_process_noise;
    logic [31:0]        w_measure_noise;
    logic [16:0]        w_quotient;

    logic signed [31:0] r_sample;
    logic signed [31:0] r_last;
    logic [31:0]        r_cov;
    logic [31:0]        r_pm;
    logic [16:0]        r_gain;
    logic signed [33:0] r_diff;
    logic [47:0]        r_prod;
    logic               r_out_valid;
    logic signed [31:0] r_estimate;

    logic               w_in_xfer;
    logic               w_wb;
    logic               w_div_start;
    logic [32:0]        w_pm_sum;
    logic [32:0]        w_denom;
    logic signed [17:0] w_mul_a;
    logic signed [33:0] w_mul_b;
    logic signed [51:0] w_mul_p;

    skf_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_process_noise (w_process_noise),
        .o_measure_noise (w_measure_noise)
    );

    skf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_pm),
        .i_divisor  (w_denom),
        .o_status   (w_div_status),
        .o_quotient (w_quotient)
    );

    assign o_ready   = (r_state == skf_pkg::S_IDLE);
    assign w_in_xfer = i_valid & o_ready;

    // Predicted covariance and denominator
    assign w_pm_sum = {1'b0, r_cov} + {1'b0, w_process_noise};
    assign w_denom  = {1'b0, r_pm} + {1'b0, w_measure_noise};

    // Shared multiplier: gain * innovation, then (1 - gain) * predicted covariance
    always_comb begin
        if (r_state == skf_pkg::S_MUL_X) begin
            w_mul_a = {1'b0, r_gain};
            w_mul_b = r_diff;
        end else begin
            w_mul_a = {1'b0, skf_pkg::ONE_Q16 - r_gain};
            w_mul_b = {2'b00, r_pm};
        end
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer strobes
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_wb        = 1'b0;
        unique case (r_state)
            skf_pkg::S_IDLE: begin
                if (w_in_xfer) n_state = skf_pkg::S_DEN;
            end
            skf_pkg::S_DEN: begin
                if (w_denom == '0) begin
                    n_state = skf_pkg::S_MUL_X;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = skf_pkg::S_DIV;
                end
            end
            skf_pkg::S_DIV: begin
                if (w_div_status.done) n_state = skf_pkg::S_MUL_X;
            end
            skf_pkg::S_MUL_X: n_state = skf_pkg::S_MUL_P;
            skf_pkg::S_MUL_P: n_state = skf_pkg::S_COV;
            skf_pkg::S_COV:   n_state = skf_pkg::S_WB;
            skf_pkg::S_WB: begin
                if (!r_out_valid || i_ready) begin
                    w_wb    = 1'b1;
                    n_state = skf_pkg::S_IDLE;
                end
            end
            default: n_state = skf_pkg::S_IDLE;
        endcase
    end

    // Filter state: last estimate and error covariance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_cov  <= '0;
        end else begin
            if (r_state == skf_pkg::S_MUL_P) r_last <= r_last + r_prod[47:16];
            if (r_state == skf_pkg::S_COV)   r_cov  <= r_prod[47:16];
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sample <= i_sample;
            r_pm     <= w_pm_sum[32] ? '1 : w_pm_sum[31:0];
        end
        if (r_state == skf_pkg::S_DEN) begin
            r_diff <= {{2{r_sample[31]}}, r_sample} - {{2{r_last[31]}}, r_last};
            if (w_denom == '0) r_gain <= skf_pkg::ONE_Q16;
        end
        if (w_div_status.done) r_gain <= w_quotient;
        if (r_state == skf_pkg::S_MUL_X || r_state == skf_pkg::S_MUL_P) begin
            r_prod <= w_mul_p[47:0];
        end
    end

    // Output register: hold the estimate until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wb) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb) r_estimate <= r_last;
    end

    assign o_valid    = r_out_valid;
    assign o_estimate = r_estimate;

    // The gain never exceeds one
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skf_pkg::S_MUL_X) |-> (r_gain <= skf_pkg::ONE_Q16))
        else $error("gain above one");

    // The divider runs only while the sequencer waits for it
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_status.busy |-> (r_state == skf_pkg::S_DIV))
        else $error("divider busy outside the divide step");

    // The updated covariance never exceeds the predicted one
    a_cov_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skf_pkg::S_COV) |-> (r_prod[47:16] <= r_pm))
        else $error("covariance grew in the update");

    // A new estimate appears only out of the write-back step
    a_wb_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wb == 1'b0 && r_out_valid == 1'b0) |=> !r_out_valid)
        else $error("estimate valid without write-back");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 20;
    localparam int PHASE_ITEMS    = 95;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_sample;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_estimate;

    scalar_kalman_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_estimate (o_estimate)
    );

    // Filter state and noise settings mirrored by the predictor
    logic signed [31:0] est_state;
    logic [31:0]        cov_state;
    logic [31:0]        q_noise;
    logic [31:0]        r_noise;

    logic [31:0]        pending_samples[$];
    logic signed [31:0] expected_estimates[$];
    int                 pushed_count;
    int                 taken_count;
    int                 error_count;
    int                 idle_cycles;
    logic               sample_taken;

    int                 gap_left;
    int                 burst_left;
    logic [15:0]        ready_pattern;
    int                 pattern_age;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic push_sample(input logic [31:0] s);
        pending_samples.push_back(s);
        pushed_count++;
    endtask

    // Block until every queued sample has been taken and every estimate has come back
    task automatic wait_drained();
        while (taken_count != pushed_count || expected_estimates.size() != 0)
            @(negedge i_clk);
    endtask

    // Write both noise registers, read them back, then update the mirrored settings
    task automatic program_noise(input logic [31:0] q, input logic [31:0] r);
        logic [31:0] value [2];
        logic [2:0]  addr;
        value[0] = q;
        value[1] = r;
        for (int k = 0; k < 2; k++) begin
            addr = (k == 0) ? {skf_pkg::REG_PROCESS_NOISE, 2'b00}
                            : {skf_pkg::REG_MEASURE_NOISE, 2'b00};
            @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr;
            pwdata  <= value[k];
            @(negedge i_clk);
            penable <= 1'b1;
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
            psel    <= 1'b1;
            pwrite  <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata !== value[k]) begin
                $display("%0t: register at %0d read back: expected %h, actual %h",
                         $time, addr, value[k], prdata);
                error_count++;
            end
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        q_noise = q;
        r_noise = r;
    endtask

    // Pick a noise setting: zero, full scale, or a spread of typical values
    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, 32'h0004_0000);
            4:       return $urandom_range(32'h0000_1000, 32'h0010_0000);
            default: return $urandom_range(0, 32'h0000_0400);
        endcase
    endfunction

    // Sample sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin : sample_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || sample_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                i_valid  <= 1'b1;
                i_sample <= pending_samples.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Estimate receiver: rotate a stall pattern, reshuffled now and then
    always @(negedge i_clk) begin : estimate_sink
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                case ($urandom_range(0, 2))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom) | 16'h0001;
                    default: ready_pattern = 16'h0001 << $urandom_range(0, 15);
                endcase
                pattern_age = $urandom_range(20, 200);
            end else begin
                pattern_age--;
            end
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            i_ready <= ready_pattern[0];
        end
    end

    // On each sample transfer, advance the predicted filter and queue its estimate
    always @(posedge i_clk) begin : filter_predictor
        logic [32:0]        pm;
        logic [33:0]        denom;
        logic [63:0]        quot;
        logic [16:0]        gain;
        logic signed [63:0] diff;
        logic signed [63:0] prod;
        logic [63:0]        pnew;
        sample_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            // predict: covariance grows by Q and saturates
            pm = {1'b0, cov_state} + {1'b0, q_noise};
            if (pm > 33'h0_FFFF_FFFF)
                pm = 33'h0_FFFF_FFFF;
            // gain in Q0.16; zero denominator means full trust in the sample
            denom = {1'b0, pm} + {2'b00, r_noise};
            if (denom == '0) begin
                gain = skf_pkg::ONE_Q16;
            end else begin
                quot = {15'd0, pm, 16'h0000} / {30'd0, denom};
                gain = quot[16:0];
            end
            // update: move toward the sample by the gain, flooring the shift
            diff = $signed({{32{i_sample[31]}}, i_sample})
                 - $signed({{32{est_state[31]}}, est_state});
            prod = $signed({47'd0, gain}) * diff;
            est_state = est_state + 32'(prod >>> 16);
            pnew = ({47'd0, skf_pkg::ONE_Q16 - gain} * {31'd0, pm}) >> 16;
            cov_state = pnew[31:0];
            expected_estimates.push_back(est_state);
            taken_count++;
        end
    end

    // Compare each estimate transfer with the oldest prediction
    always @(posedge i_clk) begin : estimate_checker
        logic signed [31:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_estimates.size() == 0) begin
                $display("%0t: estimate with none pending: expected nothing, actual %h",
                         $time, o_estimate);
                error_count++;
            end else begin
                want = expected_estimates.pop_front();
                if (o_estimate !== want) begin
                    $display("%0t: estimate mismatch: expected %h, actual %h",
                             $time, want, o_estimate);
                    error_count++;
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] fixed_a [9];
        logic [31:0] fixed_b [3];
        logic [31:0] fixed_c [5];
        logic [31:0] fixed_d [4];
        logic [31:0] fixed_e [3];
        int          level;
        int          span;
        logic [31:0] s;

        fixed_a = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555,
                    32'hAAAA_AAAA};
        fixed_b = '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF};
        fixed_c = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0000_0000};
        fixed_d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF};
        fixed_e = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000};

        // Drive every input to a known value and hold reset
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_ready       = 1'b0;
        sample_taken  = 1'b0;
        est_state     = '0;
        cov_state     = '0;
        q_noise       = 32'h0001_0000;
        r_noise       = '0;
        pushed_count  = 0;
        taken_count   = 0;
        error_count   = 0;
        idle_cycles   = 0;
        gap_left      = 0;
        burst_left    = 0;
        ready_pattern = 16'hFFFF;
        pattern_age   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset: gain of one, estimate follows the sample
        foreach (fixed_a[k]) push_sample(fixed_a[k]);
        wait_drained();

        // No noise at all: zero denominator forces gain of one
        program_noise(32'h0000_0000, 32'h0000_0000);
        foreach (fixed_b[k]) push_sample(fixed_b[k]);
        wait_drained();

        // Full-scale noise: predicted covariance saturates, swings span 33 bits
        program_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        foreach (fixed_c[k]) push_sample(fixed_c[k]);
        wait_drained();

        // No process noise, heavy measurement noise: gain decays toward zero
        program_noise(32'h0000_0000, 32'hFFFF_FFFF);
        foreach (fixed_d[k]) push_sample(fixed_d[k]);
        wait_drained();

        // Saturating process noise with exact measurements
        program_noise(32'hFFFF_FFFF, 32'h0000_0000);
        foreach (fixed_e[k]) push_sample(fixed_e[k]);

        // Random settings, each feeding a noisy drifting signal with outliers
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            program_noise(pick_noise(), pick_noise());
            level = int'($urandom);
            case ($urandom_range(0, 2))
                0:       span = 32'h0000_0100;
                1:       span = 32'h0001_0000;
                default: span = 32'h0100_0000;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0: s = $urandom;
                    1: begin
                        case ($urandom_range(0, 3))
                            0:       s = 32'h7FFF_FFFF;
                            1:       s = 32'h8000_0000;
                            2:       s = 32'h0000_0000;
                            default: s = 32'hFFFF_FFFF;
                        endcase
                    end
                    default: begin
                        level = level + int'($urandom_range(0, 8192)) - 4096;
                        s = level + int'($urandom_range(0, 2 * span)) - span;
                    end
                endcase
                push_sample(s);
            end
        end

        wait_drained();
        repeat (30) @(negedge i_clk);
        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
